// File: design/btpg_pkg.sv
package btpg_pkg;

   localparam int unsigned GLYPH_COUNT = 59;
   localparam int unsigned GLYPH_ROWS  = 5;
   localparam int unsigned GLYPH_COLS  = 5;
   localparam int unsigned GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
   localparam int unsigned GLYPH_AW    = $clog2(GLYPH_COUNT);
   localparam int unsigned COL_W       = $clog2(GLYPH_COLS);

   localparam int unsigned COORD_W = 16;
   localparam int unsigned SCALE_W = 5;
   localparam int unsigned CODE_W  = 8;
   localparam int unsigned CSR_W   = 24;

   localparam logic [CODE_W-1:0] CODE_NEWLINE     = 8'd10;
   localparam logic [CODE_W-1:0] CODE_FIRST       = 8'd32;
   localparam logic [CODE_W-1:0] CODE_END         = 8'd91;
   localparam logic [CODE_W-1:0] CODE_LOWER_FIRST = 8'd97;
   localparam logic [CODE_W-1:0] CODE_LOWER_LAST  = 8'd122;
   localparam logic [CODE_W-1:0] CASE_OFFSET      = 8'd32;

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_COLS - 1);

   typedef enum logic [1:0] {
      CSR_ORIGIN_X   = 2'd0,
      CSR_ORIGIN_Y   = 2'd1,
      CSR_SCALE      = 2'd2,
      CSR_DRAW_COLOR = 2'd3
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef logic [GLYPH_BITS-1:0] glyph_type;

   // Row 0 in the top bits, leftmost column first within each row.
   localparam glyph_type FONT_ROM [GLYPH_COUNT] = '{
      {5'd0,5'd0,5'd0,5'd0,5'd0},       {5'd4,5'd4,5'd4,5'd0,5'd4},
      {5'd10,5'd10,5'd0,5'd0,5'd0},     {5'd10,5'd31,5'd10,5'd31,5'd10},
      {5'd14,5'd20,5'd14,5'd5,5'd30},   {5'd17,5'd2,5'd4,5'd8,5'd17},
      {5'd12,5'd18,5'd12,5'd19,5'd14},  {5'd4,5'd4,5'd0,5'd0,5'd0},
      {5'd6,5'd8,5'd8,5'd8,5'd6},       {5'd12,5'd2,5'd2,5'd2,5'd12},
      {5'd0,5'd10,5'd4,5'd10,5'd0},     {5'd0,5'd4,5'd14,5'd4,5'd0},
      {5'd0,5'd0,5'd0,5'd4,5'd8},       {5'd0,5'd0,5'd14,5'd0,5'd0},
      {5'd0,5'd0,5'd0,5'd0,5'd4},       {5'd1,5'd2,5'd4,5'd8,5'd16},
      {5'd14,5'd17,5'd17,5'd17,5'd14},  {5'd4,5'd12,5'd4,5'd4,5'd14},
      {5'd14,5'd1,5'd14,5'd16,5'd31},   {5'd14,5'd1,5'd6,5'd1,5'd14},
      {5'd17,5'd17,5'd31,5'd1,5'd1},    {5'd31,5'd16,5'd30,5'd1,5'd30},
      {5'd14,5'd16,5'd30,5'd17,5'd14},  {5'd31,5'd1,5'd2,5'd4,5'd4},
      {5'd14,5'd17,5'd14,5'd17,5'd14},  {5'd14,5'd17,5'd15,5'd1,5'd14},
      {5'd0,5'd4,5'd0,5'd4,5'd0},       {5'd0,5'd4,5'd0,5'd4,5'd8},
      {5'd2,5'd4,5'd8,5'd4,5'd2},       {5'd0,5'd31,5'd0,5'd31,5'd0},
      {5'd8,5'd4,5'd2,5'd4,5'd8},       {5'd14,5'd1,5'd6,5'd0,5'd4},
      {5'd14,5'd19,5'd21,5'd19,5'd14},  {5'd14,5'd17,5'd31,5'd17,5'd17},
      {5'd30,5'd17,5'd30,5'd17,5'd30},  {5'd14,5'd16,5'd16,5'd16,5'd14},
      {5'd28,5'd18,5'd17,5'd18,5'd28},  {5'd31,5'd16,5'd30,5'd16,5'd31},
      {5'd31,5'd16,5'd30,5'd16,5'd16},  {5'd14,5'd16,5'd23,5'd17,5'd14},
      {5'd17,5'd17,5'd31,5'd17,5'd17},  {5'd14,5'd4,5'd4,5'd4,5'd14},
      {5'd7,5'd1,5'd1,5'd17,5'd14},     {5'd17,5'd18,5'd28,5'd18,5'd17},
      {5'd16,5'd16,5'd16,5'd16,5'd31},  {5'd17,5'd27,5'd21,5'd17,5'd17},
      {5'd17,5'd25,5'd21,5'd19,5'd17},  {5'd14,5'd17,5'd17,5'd17,5'd14},
      {5'd30,5'd17,5'd30,5'd16,5'd16},  {5'd14,5'd17,5'd21,5'd18,5'd13},
      {5'd30,5'd17,5'd30,5'd18,5'd17},  {5'd15,5'd16,5'd14,5'd1,5'd30},
      {5'd31,5'd4,5'd4,5'd4,5'd4},      {5'd17,5'd17,5'd17,5'd17,5'd14},
      {5'd17,5'd17,5'd17,5'd10,5'd4},   {5'd17,5'd10,5'd4,5'd4,5'd4},
      {5'd17,5'd17,5'd21,5'd27,5'd17},  {5'd17,5'd10,5'd4,5'd10,5'd17},
      {5'd31,5'd2,5'd4,5'd8,5'd31}
   };

   function automatic logic [GLYPH_AW-1:0] glyph_index(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] folded;
      logic [CODE_W-1:0] offset;
      folded = code;
      if (code >= CODE_LOWER_FIRST && code <= CODE_LOWER_LAST) begin
         folded = code - CASE_OFFSET;
      end
      offset = folded - CODE_FIRST;
      if (folded < CODE_FIRST || folded >= CODE_END) begin
         glyph_index = '0;
      end else begin
         glyph_index = offset[GLYPH_AW-1:0];
      end
   endfunction

endpackage

// File: design/btpg_req_if.sv
interface btpg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       start_of_text;

   modport source (output valid, output char_code, output start_of_text, input ready);
   modport sink (input valid, input char_code, input start_of_text, output ready);
endinterface

// File: design/btpg_rsp_if.sv
interface btpg_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] square_x;
   logic [15:0] square_y;
   logic        last_square;

   modport source (output valid, output square_x, output square_y, output last_square,
                   input ready);
   modport sink (input valid, input square_x, input square_y, input last_square,
                 output ready);
endinterface

// File: design/btpg_csr_if.sv
interface btpg_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [23:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/bitmap_text_pixel_generator.sv
// Channel  | Dir | Payload                              | Transaction
// ---------+-----+--------------------------------------+--------------------
// req_bus  | in  | char_code[7:0], start_of_text        | valid & ready
// rsp_bus  | out | square_x[15:0], square_y[15:0], last | valid & ready
// csr_bus  | in  | index[1:0], data[23:0]               | valid & ready
//
// One character at a time: the accept cycle reads the glyph ROM, then one
// glyph bit is scanned per cycle (a lit bit waits while a result stalls)
// until no lit bits remain, then the pen advances. A newline only moves it.
// Synchronous reset clears pen and origin, idles the scanner, sets scale 1.
// A stalled result holds the scanner on the next lit bit; req is refused
// until the character is finished.
module bitmap_text_pixel_generator (
   input logic         clock,
   input logic         reset,
   btpg_req_if.sink    req_bus,
   btpg_rsp_if.source  rsp_bus,
   btpg_csr_if.sink    csr_bus
);
   import btpg_pkg::*;

   state_type            state_ff, state_in;
   logic [COORD_W-1:0]   origin_x_ff, origin_y_ff;
   logic [SCALE_W-1:0]   scale_ff;
   logic [COORD_W-1:0]   pen_x_ff, pen_x_in;
   logic [COORD_W-1:0]   pen_y_ff, pen_y_in;
   logic [COORD_W-1:0]   cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]   cur_y_ff, cur_y_in;
   glyph_type            glyph_ff, glyph_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0]   rsp_y_ff, rsp_y_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [COORD_W-1:0]   scale_ext;
   logic [COORD_W-1:0]   char_adv;
   logic [COORD_W-1:0]   line_adv;
   logic [COORD_W-1:0]   base_x, base_y;
   logic                 out_free;

   assign scale_ext = {{(COORD_W-SCALE_W){1'b0}}, scale_ff};
   assign char_adv  = (scale_ext << 2) + (scale_ext << 1);
   assign line_adv  = (scale_ext << 3) - scale_ext;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.square_x    = rsp_x_ff;
   assign rsp_bus.square_y    = rsp_y_ff;
   assign rsp_bus.last_square = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         scale_ff    <= SCALE_W'(1);
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_ORIGIN_X:   origin_x_ff <= csr_bus.data[COORD_W-1:0];
            CSR_ORIGIN_Y:   origin_y_ff <= csr_bus.data[COORD_W-1:0];
            CSR_SCALE:      scale_ff    <= csr_bus.data[SCALE_W-1:0];
            CSR_DRAW_COLOR: ;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      glyph_in     = glyph_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      base_x       = req_bus.start_of_text ? origin_x_ff : pen_x_ff;
      base_y       = req_bus.start_of_text ? origin_y_ff : pen_y_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.char_code == CODE_NEWLINE) begin
                  pen_x_in = origin_x_ff;
                  pen_y_in = base_y + line_adv;
               end else begin
                  pen_x_in = base_x;
                  pen_y_in = base_y;
                  cur_x_in = base_x;
                  cur_y_in = base_y;
                  col_in   = '0;
                  glyph_in = FONT_ROM[glyph_index(req_bus.char_code)];
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (glyph_ff == '0) begin
               pen_x_in = pen_x_ff + char_adv;
               state_in = ST_IDLE;
            end else if (!glyph_ff[GLYPH_BITS-1] || out_free) begin
               if (glyph_ff[GLYPH_BITS-1]) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = cur_x_ff;
                  rsp_y_in     = cur_y_ff;
                  rsp_last_in  = (glyph_ff[GLYPH_BITS-2:0] == '0);
               end
               glyph_in = glyph_ff << 1;
               if (col_ff == LAST_COL) begin
                  col_in   = '0;
                  cur_x_in = pen_x_ff;
                  cur_y_in = cur_y_ff + scale_ext;
               end else begin
                  col_in   = col_ff + COL_W'(1);
                  cur_x_in = cur_x_ff + scale_ext;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff    <= glyph_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      col_ff      <= col_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
